### src/mcf_pkg.sv
// Shared constants and types for the magnetometer correction and filter block.
package mcf_pkg;

    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int FIELD_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int RANGE_W     = 8;
    localparam int CORR_W      = 18;
    localparam int ACC_W       = 24;
    localparam int CNT_OUT_W   = 5;
    localparam int REJ_W       = 16;
    localparam int MEAN_W      = 24;
    localparam int LEN_W       = 25;
    localparam int DIV_W       = 26;
    localparam int DREM_W      = 7;
    localparam int LEN_FRAC    = 12;

    localparam logic [SCALE_W-1:0] SCALE_MIN_Q14 = 16'd13927;
    localparam logic [SCALE_W-1:0] SCALE_MAX_Q14 = 16'd21299;
    localparam int CORR_MAX = 131071;
    localparam int CORR_MIN = -131072;
    localparam int ACC_MAX  = 8388607;
    localparam int ACC_MIN  = -8388608;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 24'hFF_FFFF;
    localparam logic [REJ_W-1:0]  REJ_MAX  = 16'hFFFF;

    localparam logic [DREM_W:0] DIV_TEN     = 8'd10;
    localparam logic [DREM_W:0] DIV_HUNDRED = 8'd100;
    localparam logic [DIV_W-1:0] ROUND_TEN     = 26'd5;
    localparam logic [DIV_W-1:0] ROUND_HUNDRED = 26'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET   = 3'd0,
        CFG_DIAG     = 3'd1,
        CFG_OFFDIAG  = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_RANGE    = 3'd4
    } cfg_index_t;

endpackage

### src/mcf_if.sv
// Valid/ready channel interfaces for raw samples and corrected results.
interface mcf_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;
    logic signed [SAMPLE_BITS-1:0] raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface mcf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  sample_ok;
    logic signed [mcf_pkg::CORR_W-1:0]     corr_x;
    logic signed [mcf_pkg::CORR_W-1:0]     corr_y;
    logic signed [mcf_pkg::CORR_W-1:0]     corr_z;
    logic signed [mcf_pkg::ACC_W-1:0]      sum_x;
    logic signed [mcf_pkg::ACC_W-1:0]      sum_y;
    logic signed [mcf_pkg::ACC_W-1:0]      sum_z;
    logic [mcf_pkg::CNT_OUT_W-1:0]         sum_count;
    logic [mcf_pkg::REJ_W-1:0]             reject_total;

    modport source (output valid, output sample_ok, output corr_x, output corr_y,
                    output corr_z, output sum_x, output sum_y, output sum_z,
                    output sum_count, output reject_total, input ready);
    modport sink   (input valid, input sample_ok, input corr_x, input corr_y,
                    input corr_z, input sum_x, input sum_y, input sum_z,
                    input sum_count, input reject_total, output ready);
endinterface

### src/mcf_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module mcf_isqrt #(
    parameter int OP_W = 50
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [OP_W-1:0]     operand,
    output logic                done,
    output logic [OP_W/2-1:0]   root
);

    localparam int RT_W  = OP_W / 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [OP_W-1:0]  op_reg, op_next;
    logic [RT_W:0]    rem_reg, rem_next;
    logic [RT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RT_W+2:0]  shifted;
    logic [RT_W+2:0]  trial;
    logic             fits;

    assign shifted = {rem_reg, op_reg[OP_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = shifted >= trial;

    always_comb
    begin
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next   = op_reg << 2;
            rem_next  = fits ? (RT_W+1)'(shifted - trial) : (RT_W+1)'(shifted);
            root_next = {root_reg[RT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/magnetometer_correct_and_filter_top.sv
// Top level: hard/soft-iron correction, field-length filter and sample accumulation.
//
// One sample at a time runs through a bit-serial shift-and-add multiplier (one
// multiplier bit per cycle), a bit-serial square root and a bit-serial constant
// divider. The scale step runs only when the scale is in range and the matrix
// always runs; the squared length, the root and the mean update run only with
// the filter on. A finished sample may wait for the output register.
// The next sample is taken while the previous result waits on the output.
module magnetometer_correct_and_filter_top #(
    parameter int MAX_SAMPLES    = 20,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcf_pkg::CFG_W-1:0]        cfg_wdata,
    mcf_in_if.sink                           in_ch,
    mcf_out_if.source                        out_ch
);

    localparam int F      = COEF_FRAC_BITS;
    localparam int V0W    = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
    localparam int VW     = (16 - F > 0) ? V0W + 16 - F : V0W;
    localparam int CW     = (F + 2 > 16) ? F + 2 : 16;
    localparam int PW0    = VW + CW + 2;
    localparam int PW     = (PW0 > 38) ? PW0 : 38;
    localparam int MBW    = (CW + 1 > 19) ? CW + 1 : 19;
    localparam int SQW    = PW + mcf_pkg::LEN_FRAC;
    localparam int NW     = ((SQW + 1) / 2) * 2;
    localparam int STEPS  = (MBW > mcf_pkg::DIV_W) ? MBW : mcf_pkg::DIV_W;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam int CNTW   = $clog2(MAX_SAMPLES + 1);
    localparam int CRW    = mcf_pkg::CORR_W;
    localparam int AW     = mcf_pkg::ACC_W;
    localparam int LW     = mcf_pkg::LEN_W;
    localparam int MW     = mcf_pkg::MEAN_W;
    localparam int DW     = mcf_pkg::DIV_W;
    localparam int RW     = mcf_pkg::DREM_W;

    localparam logic signed [PW-1:0]  ROUND_HALF = PW'(1) <<< (F - 1);
    localparam logic signed [CW-1:0]  UNITY      = CW'(1) <<< F;
    localparam logic signed [PW-1:0]  CORR_HI    = PW'(mcf_pkg::CORR_MAX);
    localparam logic signed [PW-1:0]  CORR_LO    = PW'(mcf_pkg::CORR_MIN);
    localparam logic signed [AW:0]    ACC_HI     = (AW+1)'(mcf_pkg::ACC_MAX);
    localparam logic signed [AW:0]    ACC_LO     = (AW+1)'(mcf_pkg::ACC_MIN);

    typedef enum logic [3:0] {
        S_IDLE, S_SCL, S_SCL_WB, S_MAT, S_MAT_WB, S_SQ, S_SQRT_GO, S_SQRT,
        S_CMP, S_DIV, S_UPD, S_ACC, S_DONE
    } state_t;

    // configuration
    logic [mcf_pkg::CFG_W-1:0]    offset_reg, diag_reg, offdiag_reg;
    logic [mcf_pkg::SCALE_W-1:0]  scale_reg;
    logic [mcf_pkg::RANGE_W-1:0]  range_reg;

    state_t                       state_reg, state_next;
    logic [1:0]                   k_reg, k_next, j_reg, j_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic signed [PW-1:0]         mac_reg, mac_next;
    logic signed [PW-1:0]         mcand_reg, mcand_next;
    logic signed [MBW-1:0]        mplier_reg, mplier_next;
    logic signed [VW-1:0]         v_reg [3];
    logic signed [VW-1:0]         v_next [3];
    logic signed [CRW-1:0]        c_reg [3];
    logic signed [CRW-1:0]        c_next [3];
    logic signed [AW-1:0]         acc_reg [3];
    logic signed [AW-1:0]         acc_next [3];
    logic [CNTW-1:0]              cnt_reg, cnt_next;
    logic [MW-1:0]                mean_reg, mean_next;
    logic [mcf_pkg::REJ_W-1:0]    rej_cnt_reg, rej_cnt_next;
    logic [LW-1:0]                len_reg, len_next;
    logic                         ok_reg, ok_next;
    logic                         rej_reg, rej_next;
    logic                         up_reg, up_next;
    logic [DW-1:0]                div_reg, div_next;
    logic [RW-1:0]                drem_reg, drem_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_ok_reg, out_ok_next;
    logic signed [CRW-1:0]        out_c_reg [3];
    logic signed [CRW-1:0]        out_c_next [3];
    logic signed [AW-1:0]         out_s_reg [3];
    logic signed [AW-1:0]         out_s_next [3];
    logic [mcf_pkg::CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [mcf_pkg::REJ_W-1:0]    out_rej_reg, out_rej_next;

    // datapath helpers
    logic signed [VW-1:0]         v_in [3];
    logic signed [CW-1:0]         coef [3][3];
    logic signed [CW-1:0]         diag_eff [3];
    logic signed [CW-1:0]         offd [3];
    logic                         diag_zero;
    logic                         scale_ok;
    logic signed [PW-1:0]         mul_add, mac_step, rnd_val;
    logic                         mul_last, div_last;
    logic signed [CRW-1:0]        c_sat;
    logic                         sqrt_start, sqrt_done;
    logic [NW/2-1:0]              sqrt_root;
    logic [LW-1:0]                root_len;
    logic [DW-1:0]                ml_sum, diff;
    logic [DW+7:0]                lhs, rhs;
    logic                         len_up;
    logic [RW:0]                  dshift, divisor;
    logic                         dfit;
    logic [DW:0]                  m_up, m_dn;
    logic [DW:0]                  m_upd;
    logic signed [AW:0]           acc_sum [3];
    logic signed [AW-1:0]         acc_sat [3];
    logic [CNTW-1:0]              cnt_inc;
    logic                         halve;

    assign v_in[0] = VW'(in_ch.raw_x) + VW'($signed(offset_reg[15:0]));
    assign v_in[1] = VW'(in_ch.raw_y) + VW'($signed(offset_reg[31:16]));
    assign v_in[2] = VW'(in_ch.raw_z) + VW'($signed(offset_reg[47:32]));

    assign diag_zero = (diag_reg == '0);
    assign scale_ok  = (scale_reg >= mcf_pkg::SCALE_MIN_Q14) &&
                       (scale_reg <= mcf_pkg::SCALE_MAX_Q14);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diag_eff[i] = diag_zero ? UNITY : CW'($signed(diag_reg[16*i +: 16]));
            offd[i]     = CW'($signed(offdiag_reg[16*i +: 16]));
        end
        coef[0][0] = diag_eff[0]; coef[0][1] = offd[0];     coef[0][2] = offd[1];
        coef[1][0] = offd[0];     coef[1][1] = diag_eff[1]; coef[1][2] = offd[2];
        coef[2][0] = offd[1];     coef[2][1] = offd[2];     coef[2][2] = diag_eff[2];
    end

    assign mul_add  = mplier_reg[0] ? mcand_reg : '0;
    assign mul_last = (step_reg == STEP_W'(MBW - 1));
    assign mac_step = mul_last ? mac_reg - mul_add : mac_reg + mul_add;
    assign rnd_val  = (mac_reg + ROUND_HALF) >>> F;
    assign c_sat    = (rnd_val > CORR_HI) ? CRW'(CORR_HI) :
                      (rnd_val < CORR_LO) ? CRW'(CORR_LO) : CRW'(rnd_val);

    assign sqrt_start = (state_reg == S_SQRT_GO);
    assign root_len   = LW'(sqrt_root);

    mcf_isqrt #(
        .OP_W (NW)
    ) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (NW'({mac_reg, {mcf_pkg::LEN_FRAC{1'b0}}})),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign len_up = (LW'(mean_reg) <= len_reg);
    assign ml_sum = DW'(mean_reg) + DW'(len_reg);
    assign diff   = len_up ? DW'(len_reg) - DW'(mean_reg) : DW'(mean_reg) - DW'(len_reg);
    assign lhs    = ((DW+8)'(diff) << 7) + ((DW+8)'(diff) << 6) + ((DW+8)'(diff) << 3);
    assign rhs    = (DW+8)'(range_reg) * (DW+8)'(ml_sum);

    assign divisor  = rej_reg ? mcf_pkg::DIV_HUNDRED : mcf_pkg::DIV_TEN;
    assign dshift   = {drem_reg, div_reg[DW-1]};
    assign dfit     = (dshift >= divisor);
    assign div_last = (step_reg == STEP_W'(DW - 1));

    assign m_up  = (DW+1)'(mean_reg) + (DW+1)'(div_reg);
    assign m_dn  = ((DW+1)'(div_reg) > (DW+1)'(mean_reg)) ? '0 :
                   (DW+1)'(mean_reg) - (DW+1)'(div_reg);
    assign m_upd = up_reg ? m_up : m_dn;

    assign cnt_inc = cnt_reg + 1'b1;
    assign halve   = (cnt_inc >= CNTW'(MAX_SAMPLES));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_sum[i] = (AW+1)'(acc_reg[i]) + (AW+1)'(c_reg[i]);
            acc_sat[i] = (acc_sum[i] > ACC_HI) ? AW'(ACC_HI) :
                         (acc_sum[i] < ACC_LO) ? AW'(ACC_LO) : AW'(acc_sum[i]);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        step_next    = step_reg;
        mac_next     = mac_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        v_next       = v_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        mean_next    = mean_reg;
        rej_cnt_next = rej_cnt_reg;
        len_next     = len_reg;
        ok_next      = ok_reg;
        rej_next     = rej_reg;
        up_next      = up_reg;
        div_next     = div_reg;
        drem_next    = drem_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_ok_next  = out_ok_reg;
        out_c_next   = out_c_reg;
        out_s_next   = out_s_reg;
        out_cnt_next = out_cnt_reg;
        out_rej_next = out_rej_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    v_next     = v_in;
                    k_next     = 2'd0;
                    j_next     = 2'd0;
                    step_next  = '0;
                    mac_next   = '0;
                    mcand_next = PW'(v_in[0]);
                    if (scale_ok)
                    begin
                        mplier_next = MBW'(scale_reg);
                        state_next  = S_SCL;
                    end
                    else
                    begin
                        mplier_next = MBW'(coef[0][0]);
                        state_next  = S_MAT;
                    end
                end
            end
            S_SCL, S_MAT, S_SQ:
            begin
                mac_next    = mac_step;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >>> 1;
                step_next   = step_reg + 1'b1;
                if (mul_last)
                begin
                    step_next = '0;
                    if (state_reg == S_SCL)
                        state_next = S_SCL_WB;
                    else if (state_reg == S_MAT)
                    begin
                        if (j_reg == 2'd2)
                            state_next = S_MAT_WB;
                        else
                        begin
                            j_next      = j_reg + 2'd1;
                            mcand_next  = PW'(v_reg[j_reg + 2'd1]);
                            mplier_next = MBW'(coef[k_reg][j_reg + 2'd1]);
                        end
                    end
                    else
                    begin
                        if (k_reg == 2'd2)
                            state_next = S_SQRT_GO;
                        else
                        begin
                            k_next      = k_reg + 2'd1;
                            mcand_next  = PW'(c_reg[k_reg + 2'd1]);
                            mplier_next = MBW'(c_reg[k_reg + 2'd1]);
                        end
                    end
                end
            end
            S_SCL_WB:
            begin
                v_next[k_reg] = VW'(rnd_val);
                mac_next      = '0;
                step_next     = '0;
                if (k_reg == 2'd2)
                begin
                    k_next      = 2'd0;
                    j_next      = 2'd0;
                    mcand_next  = PW'(v_reg[0]);
                    mplier_next = MBW'(coef[0][0]);
                    state_next  = S_MAT;
                end
                else
                begin
                    k_next      = k_reg + 2'd1;
                    mcand_next  = PW'(v_reg[k_reg + 2'd1]);
                    mplier_next = MBW'(scale_reg);
                    state_next  = S_SCL;
                end
            end
            S_MAT_WB:
            begin
                c_next[k_reg] = c_sat;
                mac_next      = '0;
                step_next     = '0;
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    if (range_reg == '0)
                    begin
                        ok_next    = 1'b1;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        mcand_next  = PW'(c_reg[0]);
                        mplier_next = MBW'(c_reg[0]);
                        state_next  = S_SQ;
                    end
                end
                else
                begin
                    k_next      = k_reg + 2'd1;
                    j_next      = 2'd0;
                    mcand_next  = PW'(v_reg[0]);
                    mplier_next = MBW'(coef[k_reg + 2'd1][0]);
                    state_next  = S_MAT;
                end
            end
            S_SQRT_GO:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_next = root_len;
                    if (mean_reg == '0)
                    begin
                        mean_next  = (root_len > LW'(mcf_pkg::MEAN_MAX)) ?
                                     mcf_pkg::MEAN_MAX : MW'(root_len);
                        ok_next    = 1'b1;
                        state_next = S_ACC;
                    end
                    else
                        state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                rej_next   = (lhs > rhs);
                up_next    = len_up;
                div_next   = (lhs > rhs) ? ml_sum + mcf_pkg::ROUND_HUNDRED :
                                           diff + mcf_pkg::ROUND_TEN;
                drem_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                drem_next = dfit ? RW'(dshift - divisor) : RW'(dshift);
                div_next  = {div_reg[DW-2:0], dfit};
                step_next = step_reg + 1'b1;
                if (div_last)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                mean_next = (m_upd > (DW+1)'(mcf_pkg::MEAN_MAX)) ?
                            mcf_pkg::MEAN_MAX : MW'(m_upd);
                if (rej_reg)
                begin
                    if (rej_cnt_reg != mcf_pkg::REJ_MAX)
                        rej_cnt_next = rej_cnt_reg + 1'b1;
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                for (int i = 0; i < 3; i++)
                    acc_next[i] = halve ? (acc_sat[i] >>> 1) : acc_sat[i];
                cnt_next   = halve ? (cnt_inc >> 1) : cnt_inc;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_c_next     = c_reg;
                    out_s_next     = acc_reg;
                    out_cnt_next   = mcf_pkg::CNT_OUT_W'(cnt_reg);
                    out_rej_next   = rej_cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            rej_cnt_reg   <= '0;
            ok_reg        <= 1'b0;
            rej_reg       <= 1'b0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= '0;
            diag_reg      <= '0;
            offdiag_reg   <= '0;
            scale_reg     <= '0;
            range_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            rej_cnt_reg   <= rej_cnt_next;
            ok_reg        <= ok_next;
            rej_reg       <= rej_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mcf_pkg::CFG_OFFSET:  offset_reg  <= cfg_wdata;
                    mcf_pkg::CFG_DIAG:    diag_reg    <= cfg_wdata;
                    mcf_pkg::CFG_OFFDIAG: offdiag_reg <= cfg_wdata;
                    mcf_pkg::CFG_SCALE:   scale_reg   <= cfg_wdata[mcf_pkg::SCALE_W-1:0];
                    mcf_pkg::CFG_RANGE:   range_reg   <= cfg_wdata[mcf_pkg::RANGE_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg     <= mac_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        v_reg       <= v_next;
        c_reg       <= c_next;
        len_reg     <= len_next;
        div_reg     <= div_next;
        drem_reg    <= drem_next;
        out_ok_reg  <= out_ok_next;
        out_c_reg   <= out_c_next;
        out_s_reg   <= out_s_next;
        out_cnt_reg <= out_cnt_next;
        out_rej_reg <= out_rej_next;
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_ok    = out_ok_reg;
    assign out_ch.corr_x       = out_c_reg[0];
    assign out_ch.corr_y       = out_c_reg[1];
    assign out_ch.corr_z       = out_c_reg[2];
    assign out_ch.sum_x        = out_s_reg[0];
    assign out_ch.sum_y        = out_s_reg[1];
    assign out_ch.sum_z        = out_s_reg[2];
    assign out_ch.sum_count    = out_cnt_reg;
    assign out_ch.reject_total = out_rej_reg;

    a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNTW'(MAX_SAMPLES))
        else $error("sample count reached the halving limit");

    a_filter_off_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && range_reg == '0) |-> ok_reg)
        else $error("sample rejected with the filter disabled");

    a_rej_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rej_cnt_reg >= $past(rej_cnt_reg))
        else $error("reject count decreased");

    a_sqrt_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == S_SQRT)
        else $error("square root finished outside its wait state");

endmodule
